// ===== hdl/tanhr_pkg.sv =====
// ----------------------------------------------------------------------------
// tanhr_pkg
// Shared types and constants of the tree-address next-hop router: register
// map, status and rule codes, configuration and result bundles.
// ----------------------------------------------------------------------------
package tanhr_pkg;

  // address width of the mesh
  localparam int unsigned AddrBits = 16;

  // configuration register map (word index on the register port)
  localparam int unsigned RegIdxBits = 3;
  localparam int unsigned PaddrBits  = RegIdxBits + 2;
  localparam logic [RegIdxBits-1:0] RegBranching = 3'd0;
  localparam logic [RegIdxBits-1:0] RegDepth     = 3'd1;
  localparam logic [RegIdxBits-1:0] RegLeafCount = 3'd2;
  localparam logic [RegIdxBits-1:0] RegOwnAddr   = 3'd3;
  localparam logic [RegIdxBits-1:0] RegParent    = 3'd4;

  // reset values
  localparam logic [3:0] BranchingReset = 4'd4;

  // route status codes
  localparam logic [1:0] StatusForward = 2'd0;
  localparam logic [1:0] StatusNoRoute = 2'd1;
  localparam logic [1:0] StatusCfgErr  = 2'd2;

  // routing rule codes
  localparam logic [2:0] RuleCfgErr    = 3'd0;
  localparam logic [2:0] RuleDirect    = 3'd1;
  localparam logic [2:0] RuleOutside   = 3'd2;
  localparam logic [2:0] RuleSameBlock = 3'd3;
  localparam logic [2:0] RuleBlockBase = 3'd4;
  localparam logic [2:0] RuleParent    = 3'd5;

  // node configuration
  typedef struct packed {
    logic [3:0]          branching_bits;
    logic [4:0]          tree_depth;
    logic [14:0]         leaf_block_count;
    logic [AddrBits-1:0] own_address;
    logic [AddrBits-1:0] parent_hop;
  } cfg_t;

  // one routing decision
  typedef struct packed {
    logic [AddrBits-1:0] next_hop_address;
    logic [1:0]          route_status;
    logic [2:0]          rule_applied;
  } route_t;

endpackage

// ===== hdl/tanhr_route.sv =====
// ----------------------------------------------------------------------------
// tanhr_route
// Combinational next-hop decision for one packet: derives this node's space
// and child block masks from the configuration and applies the routing rules.
// ----------------------------------------------------------------------------
module tanhr_route (
  input  tanhr_pkg::cfg_t                  cfg_i,
  input  logic [tanhr_pkg::AddrBits-1:0]   src_i,
  input  logic [tanhr_pkg::AddrBits-1:0]   dst_i,
  output tanhr_pkg::route_t                route_o
);
  import tanhr_pkg::*;

  localparam int unsigned ExpBits  = $clog2(AddrBits + 1);
  localparam int unsigned UsedBits = 9;
  localparam int unsigned SpanBits = 2 * AddrBits;

  logic [UsedBits-1:0] used;
  logic                cfg_err;
  logic [ExpBits-1:0]  space_exp;
  logic [ExpBits-1:0]  block_exp;
  logic [AddrBits:0]   node_lo_w;
  logic [AddrBits:0]   child_lo_w;
  logic [AddrBits-1:0] node_lo;
  logic [AddrBits-1:0] child_lo;
  logic [AddrBits-1:0] base;
  logic [SpanBits-1:0] leaf_span;
  logic                dst_in;
  logic                src_in;
  logic                dst_in_leaf;
  logic                dst_is_base;
  logic                same_block;

  // levels above this node consume depth * branching address bits
  assign used    = UsedBits'(cfg_i.tree_depth) * UsedBits'(cfg_i.branching_bits);
  assign cfg_err = (used > UsedBits'(AddrBits));

  // space and child block exponents, block exponent clamped at zero
  assign space_exp = cfg_err ? '0 : ExpBits'(UsedBits'(AddrBits) - used);
  assign block_exp = (space_exp > ExpBits'(cfg_i.branching_bits))
                   ? space_exp - ExpBits'(cfg_i.branching_bits) : '0;

  // low masks of the space and of one child block
  assign node_lo_w  = ((AddrBits+1)'(1) << space_exp) - (AddrBits+1)'(1);
  assign child_lo_w = ((AddrBits+1)'(1) << block_exp) - (AddrBits+1)'(1);
  assign node_lo    = node_lo_w[AddrBits-1:0];
  assign child_lo   = child_lo_w[AddrBits-1:0];
  assign base       = cfg_i.own_address & ~node_lo;

  // leaf range spans (1 + leaf blocks) child blocks, kept exact
  assign leaf_span = (SpanBits'(cfg_i.leaf_block_count) + SpanBits'(1)) << block_exp;

  // membership and block tests
  assign dst_in      = ((dst_i & ~node_lo) == base);
  assign src_in      = ((src_i & ~node_lo) == base);
  assign dst_in_leaf = (SpanBits'(dst_i & node_lo) < leaf_span);
  assign dst_is_base = ((dst_i & child_lo) == '0);
  assign same_block  = ((dst_i & ~child_lo) == (src_i & ~child_lo));

  // rule selection, first match wins
  always_comb begin
    route_o = '0;
    priority if (cfg_err) begin
      route_o.route_status = StatusCfgErr;
      route_o.rule_applied = RuleCfgErr;
    end else if (dst_in && (dst_in_leaf || dst_is_base)) begin
      route_o.next_hop_address = dst_i;
      route_o.route_status     = StatusForward;
      route_o.rule_applied     = RuleDirect;
    end else if (dst_in && src_in && same_block) begin
      route_o.route_status = StatusNoRoute;
      route_o.rule_applied = RuleSameBlock;
    end else if (dst_in) begin
      route_o.next_hop_address = dst_i & ~child_lo;
      route_o.route_status     = StatusForward;
      route_o.rule_applied     = RuleBlockBase;
    end else if (src_in) begin
      route_o.next_hop_address = cfg_i.parent_hop;
      route_o.route_status     = StatusForward;
      route_o.rule_applied     = RuleParent;
    end else begin
      route_o.route_status = StatusNoRoute;
      route_o.rule_applied = RuleOutside;
    end
  end

endmodule

// ===== hdl/tree_address_next_hop_router.sv =====
// ----------------------------------------------------------------------------
// tree_address_next_hop_router
// Next-hop decision for packets in a tree-addressed mesh.
//
// Input channel carries a packet's source and destination address; output
// channel carries next hop, route status and the rule that decided. Both use
// valid/stall: a transfer happens on a clock edge with valid high and stall
// low.
// The accepted item is held in an input register and the decision, short
// combinational logic, is captured in the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// only limit is the result register, and the input register still takes an
// item while a result waits. When the receiver stalls, the result register
// holds its value, then the input register fills and in_stall_o rises.
// Reset empties both registers and loads the default configuration
// (branching 4, depth 0, everything else zero). The APB port writes and reads
// the five configuration registers at byte addresses 0, 4, .. 16; pready is
// always high. The user must write configuration while idle; unenforced.
// ----------------------------------------------------------------------------
module tree_address_next_hop_router (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tanhr_pkg::PaddrBits-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // packet channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tanhr_pkg::AddrBits-1:0]      source_address_i,
  input  logic [tanhr_pkg::AddrBits-1:0]      dest_address_i,
  // decision channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tanhr_pkg::AddrBits-1:0]      next_hop_address_o,
  output logic [1:0]                          route_status_o,
  output logic [2:0]                          rule_applied_o
);
  import tanhr_pkg::*;

  cfg_t                cfg_q;
  logic                cfg_wr;
  logic [RegIdxBits-1:0] reg_idx;

  logic                in_valid_q;
  logic [AddrBits-1:0] src_q;
  logic [AddrBits-1:0] dst_q;
  logic                out_valid_q;
  route_t              res_q;
  route_t              res_d;

  logic                out_free;
  logic                in_xfer;
  logic                advance;

  // register port decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrBits-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.branching_bits   <= BranchingReset;
      cfg_q.tree_depth       <= '0;
      cfg_q.leaf_block_count <= '0;
      cfg_q.own_address      <= '0;
      cfg_q.parent_hop       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBranching: cfg_q.branching_bits   <= pwdata[3:0];
        RegDepth:     cfg_q.tree_depth       <= pwdata[4:0];
        RegLeafCount: cfg_q.leaf_block_count <= pwdata[14:0];
        RegOwnAddr:   cfg_q.own_address      <= pwdata[AddrBits-1:0];
        RegParent:    cfg_q.parent_hop       <= pwdata[AddrBits-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegBranching: prdata[3:0]          = cfg_q.branching_bits;
      RegDepth:     prdata[4:0]          = cfg_q.tree_depth;
      RegLeafCount: prdata[14:0]         = cfg_q.leaf_block_count;
      RegOwnAddr:   prdata[AddrBits-1:0] = cfg_q.own_address;
      RegParent:    prdata[AddrBits-1:0] = cfg_q.parent_hop;
      default:      prdata               = '0;
    endcase
  end

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      src_q <= source_address_i;
      dst_q <= dest_address_i;
    end
  end

  // routing decision
  tanhr_route u_route (
    .cfg_i   (cfg_q),
    .src_i   (src_q),
    .dst_i   (dst_q),
    .route_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_hop_address_o = res_q.next_hop_address;
  assign route_status_o     = res_q.route_status;
  assign rule_applied_o     = res_q.rule_applied;

endmodule
